[design/sdsu_pkg.sv]
// ----------------------------------------------------------------------------
// sdsu_pkg
// Shared types and constants of the stack machine data stack unit.
// ----------------------------------------------------------------------------
package sdsu_pkg;

  localparam int DATA_W          = 32;
  localparam int OP_W            = 5;
  localparam int ST_W            = 3;
  localparam int CNT_OUT_W       = 7;
  localparam int STACK_DEPTH_DEF = 64;

  typedef enum logic [OP_W-1:0] {
    OP_LIT       = 5'd0,
    OP_ADD       = 5'd1,
    OP_SUB       = 5'd2,
    OP_MUL       = 5'd3,
    OP_DIV       = 5'd4,
    OP_MOD       = 5'd5,
    OP_EQ        = 5'd6,
    OP_NE        = 5'd7,
    OP_GT        = 5'd8,
    OP_LT        = 5'd9,
    OP_GE        = 5'd10,
    OP_LE        = 5'd11,
    OP_NOT       = 5'd12,
    OP_AND       = 5'd13,
    OP_OR        = 5'd14,
    OP_DUP       = 5'd15,
    OP_DROP      = 5'd16,
    OP_SWAP      = 5'd17,
    OP_DEPTH     = 5'd18,
    OP_PICK      = 5'd19,
    OP_POKE      = 5'd20,
    OP_BRANCH    = 5'd21,
    OP_BRANCH_IF = 5'd22,
    OP_OUT       = 5'd23
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_INDEX = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic cap_a;
    logic rd_x;
    logic cap_x;
    logic div_start;
    logic commit;
    logic commit2;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_rx;
    logic need_div;
    logic is_swap;
    logic div_busy;
  } dp_stat_t;

endpackage

[design/sdsu_if.sv]
// ----------------------------------------------------------------------------
// sdsu_if
// Valid/ready channels of the data stack unit: instruction in, result out.
// ----------------------------------------------------------------------------
interface sdsu_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         opcode;
  logic signed [31:0] literal;

  modport source (output valid, opcode, literal, input ready);
  modport sink   (input valid, opcode, literal, output ready);
endinterface

interface sdsu_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] top_value;
  logic [6:0]         stack_count;
  logic               jump_valid;
  logic signed [31:0] jump_target;
  logic               emit_valid;
  logic signed [31:0] emit_value;

  modport source (output valid, status, top_value, stack_count, jump_valid, jump_target,
                  emit_valid, emit_value, input ready);
  modport sink   (input valid, status, top_value, stack_count, jump_valid, jump_target,
                  emit_valid, emit_value, output ready);
endinterface

[design/sdsu_ram.sv]
// ----------------------------------------------------------------------------
// sdsu_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module sdsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                     wdata,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[design/sdsu_div.sv]
// ----------------------------------------------------------------------------
// sdsu_div
// Signed 32-bit divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module sdsu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quo,
  output logic [31:0] rem
);
  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [31:0] n_r, d_r, r_r;
  logic        nq_r, nr_r;
  logic [32:0] r_sh, diff;
  logic        ge;

  assign r_sh = {r_r, n_r[31]};
  assign diff = r_sh - {1'b0, d_r};
  assign ge   = ~diff[32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r  <= dividend[31] ? (32'd0 - dividend) : dividend;
      d_r  <= divisor[31] ? (32'd0 - divisor) : divisor;
      r_r  <= '0;
      nq_r <= dividend[31] ^ divisor[31];
      nr_r <= dividend[31];
    end else if (busy_r) begin
      r_r <= ge ? diff[31:0] : r_sh[31:0];
      n_r <= {n_r[30:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = nq_r ? (32'd0 - n_r) : n_r;
  assign rem  = nr_r ? (32'd0 - r_r) : r_r;
endmodule

[design/sdsu_dp.sv]
// ----------------------------------------------------------------------------
// sdsu_dp
// Datapath: stack RAM, cached top of stack, fill count, ALU and divider.
// ----------------------------------------------------------------------------
module sdsu_dp #(
  parameter int DEPTH = sdsu_pkg::STACK_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sdsu_pkg::ctrl_cmd_t   cmd,
  output sdsu_pkg::dp_stat_t    stat,
  input  logic [4:0]            in_opcode,
  input  logic signed [31:0]    in_literal,
  output logic [2:0]            out_status,
  output logic signed [31:0]    out_top_value,
  output logic [6:0]            out_stack_count,
  output logic                  out_jump_valid,
  output logic signed [31:0]    out_jump_target,
  output logic                  out_emit_valid,
  output logic signed [31:0]    out_emit_value
);
  import sdsu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_t             op_r;
  logic [31:0]     lit_r, top_r, a_r, x_r;
  logic [CW-1:0]   fill_r;
  status_t         st_r;
  logic            jv_r, ev_r;
  logic [31:0]     jt_r, evv_r;

  logic [CW-1:0]   fm1, fm2, fm3, fill_nxt;
  logic [31:0]     fm1_x, fm2_x, fm3_x, rdata, alu_r, top_nxt, w_data, jt_nxt, evv_nxt;
  logic [AW-1:0]   ram_addr, w_addr, x_addr;
  logic            ram_we, w_en, divz, under, over, pushes, jv_nxt, ev_nxt;
  logic [1:0]      needs;
  status_t         st_nxt;
  logic            div_busy;
  logic [31:0]     div_q, div_rem;

  assign fm1   = fill_r - CW'(1);
  assign fm2   = fill_r - CW'(2);
  assign fm3   = fill_r - CW'(3);
  assign fm1_x = 32'(fm1);
  assign fm2_x = 32'(fm2);
  assign fm3_x = 32'(fm3);

  always_comb begin
    needs  = 2'd0;
    pushes = 1'b0;
    case (op_r)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE,
      OP_AND, OP_OR, OP_SWAP, OP_POKE, OP_BRANCH_IF: needs = 2'd2;
      OP_NOT, OP_DROP, OP_PICK, OP_BRANCH, OP_OUT:   needs = 2'd1;
      OP_DUP: begin
        needs  = 2'd1;
        pushes = 1'b1;
      end
      OP_LIT, OP_DEPTH: pushes = 1'b1;
      default: ;
    endcase
  end

  assign under = fill_r < CW'(needs);
  assign over  = pushes && (fill_r >= CW'(DEPTH));

  assign stat.need_rx  = !under && (op_r == OP_PICK || op_r == OP_POKE ||
                                    op_r == OP_BRANCH_IF);
  assign stat.need_div = !under && (op_r == OP_DIV || op_r == OP_MOD) && (top_r != 32'd0);
  assign stat.is_swap  = !under && (op_r == OP_SWAP);
  assign stat.div_busy = div_busy;

  sdsu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rdata),
    .divisor  (top_r),
    .busy     (div_busy),
    .quo      (div_q),
    .rem      (div_rem)
  );

  // a = second entry (a_r), b = top (top_r)
  always_comb begin
    divz  = 1'b0;
    alu_r = '0;
    case (op_r)
      OP_ADD: alu_r = a_r + top_r;
      OP_SUB: alu_r = a_r - top_r;
      OP_MUL: alu_r = a_r * top_r;
      OP_DIV, OP_MOD: begin
        if (top_r == 32'd0) begin
          divz = 1'b1;
        end else begin
          alu_r = (op_r == OP_DIV) ? div_q : div_rem;
        end
      end
      OP_EQ:  alu_r = (a_r == top_r) ? '1 : '0;
      OP_NE:  alu_r = (a_r != top_r) ? '1 : '0;
      OP_GT:  alu_r = 32'($signed(a_r) > $signed(top_r));
      OP_LT:  alu_r = 32'($signed(a_r) < $signed(top_r));
      OP_GE:  alu_r = 32'($signed(a_r) >= $signed(top_r));
      OP_LE:  alu_r = 32'($signed(a_r) <= $signed(top_r));
      OP_NOT: alu_r = 32'(top_r == 32'd0);
      OP_AND: alu_r = a_r & top_r;
      OP_OR:  alu_r = a_r | top_r;
      default: ;
    endcase
  end

  always_comb begin
    w_en     = 1'b0;
    w_addr   = fm2[AW-1:0];
    w_data   = top_r;
    fill_nxt = fill_r;
    top_nxt  = top_r;
    st_nxt   = ST_OK;
    jv_nxt   = 1'b0;
    jt_nxt   = '0;
    ev_nxt   = 1'b0;
    evv_nxt  = '0;
    if (under) begin
      fill_nxt = '0;
      st_nxt   = ST_UNDER;
    end else if (over) begin
      st_nxt = ST_OVER;
    end else begin
      case (op_r)
        OP_LIT: begin
          w_en     = 1'b1;
          w_addr   = fill_r[AW-1:0];
          w_data   = lit_r;
          fill_nxt = fill_r + CW'(1);
          top_nxt  = lit_r;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE,
        OP_AND, OP_OR: begin
          w_en     = 1'b1;
          w_data   = alu_r;
          fill_nxt = fm1;
          top_nxt  = alu_r;
          if (divz) begin
            st_nxt = ST_DIVZ;
          end
        end
        OP_NOT: begin
          w_en    = 1'b1;
          w_addr  = fm1[AW-1:0];
          w_data  = alu_r;
          top_nxt = alu_r;
        end
        OP_DUP: begin
          w_en     = 1'b1;
          w_addr   = fill_r[AW-1:0];
          fill_nxt = fill_r + CW'(1);
        end
        OP_DROP: begin
          fill_nxt = fm1;
          top_nxt  = a_r;
        end
        OP_SWAP: begin
          // second half of the exchange goes out in the following cycle
          w_en = 1'b1;
        end
        OP_DEPTH: begin
          w_en     = 1'b1;
          w_addr   = fill_r[AW-1:0];
          w_data   = 32'(fill_r) - 32'd1;
          fill_nxt = fill_r + CW'(1);
          top_nxt  = 32'(fill_r) - 32'd1;
        end
        OP_PICK: begin
          if (top_r < fm1_x) begin
            w_en    = 1'b1;
            w_addr  = fm1[AW-1:0];
            w_data  = x_r;
            top_nxt = x_r;
          end else begin
            fill_nxt = fm1;
            top_nxt  = a_r;
            st_nxt   = ST_INDEX;
          end
        end
        OP_POKE: begin
          fill_nxt = fm2;
          top_nxt  = x_r;
          if (top_r < fm2_x) begin
            w_en   = 1'b1;
            w_addr = top_r[AW-1:0];
            w_data = a_r;
            if (top_r == fm3_x) begin
              top_nxt = a_r;
            end
          end else begin
            st_nxt = ST_INDEX;
          end
        end
        OP_BRANCH: begin
          fill_nxt = fm1;
          top_nxt  = a_r;
          jv_nxt   = 1'b1;
          jt_nxt   = top_r;
        end
        OP_BRANCH_IF: begin
          fill_nxt = fm2;
          top_nxt  = x_r;
          if (a_r != 32'd0) begin
            jv_nxt = 1'b1;
            jt_nxt = top_r;
          end
        end
        OP_OUT: begin
          fill_nxt = fm1;
          top_nxt  = a_r;
          ev_nxt   = 1'b1;
          evv_nxt  = top_r;
        end
        default: ;
      endcase
    end
  end

  assign x_addr = (op_r == OP_PICK) ? top_r[AW-1:0] : fm3[AW-1:0];

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = fm2[AW-1:0];
    if (cmd.commit2) begin
      ram_we   = 1'b1;
      ram_addr = fm1[AW-1:0];
    end else if (cmd.commit) begin
      ram_we   = w_en;
      ram_addr = w_addr;
    end else if (cmd.rd_x) begin
      ram_addr = x_addr;
    end
  end

  sdsu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cmd.commit2 ? a_r : w_data),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.commit) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= op_t'(in_opcode);
      lit_r <= in_literal;
    end
    if (cmd.cap_a) begin
      a_r <= rdata;
    end
    if (cmd.cap_x) begin
      x_r <= rdata;
    end
    if (cmd.commit) begin
      top_r <= top_nxt;
      st_r  <= st_nxt;
      jv_r  <= jv_nxt;
      jt_r  <= jt_nxt;
      ev_r  <= ev_nxt;
      evv_r <= evv_nxt;
    end else if (cmd.commit2) begin
      top_r <= a_r;
    end
  end

  assign out_status      = st_r;
  assign out_top_value   = (fill_r != '0) ? top_r : '0;
  assign out_stack_count = CNT_OUT_W'(fill_r);
  assign out_jump_valid  = jv_r;
  assign out_jump_target = jt_r;
  assign out_emit_valid  = ev_r;
  assign out_emit_value  = evv_r;
endmodule

[design/sdsu_ctrl.sv]
// ----------------------------------------------------------------------------
// sdsu_ctrl
// Sequencer: steps one primitive through read, execute, write and result.
// ----------------------------------------------------------------------------
module sdsu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sdsu_pkg::dp_stat_t  stat,
  output sdsu_pkg::ctrl_cmd_t cmd
);
  import sdsu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_EX, S_RX, S_RXW, S_DV, S_W1, S_W2, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RA;
      S_RA:   state_nxt = S_EX;
      S_EX: begin
        if (stat.need_rx) begin
          state_nxt = S_RX;
        end else if (stat.need_div) begin
          state_nxt = S_DV;
        end else begin
          state_nxt = S_W1;
        end
      end
      S_RX:   state_nxt = S_RXW;
      S_RXW:  state_nxt = S_W1;
      S_DV:   if (!stat.div_busy) state_nxt = S_W1;
      S_W1:   state_nxt = stat.is_swap ? S_W2 : S_OUT;
      S_W2:   state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = (state_r == S_OUT);
  assign cmd.accept    = (state_r == S_IDLE) && in_valid;
  assign cmd.cap_a     = (state_r == S_EX);
  assign cmd.div_start = (state_r == S_EX) && stat.need_div;
  assign cmd.rd_x      = (state_r == S_RX);
  assign cmd.cap_x     = (state_r == S_RXW);
  assign cmd.commit    = (state_r == S_W1);
  assign cmd.commit2   = (state_r == S_W2);
endmodule

[design/stack_machine_data_stack_unit.sv]
// ----------------------------------------------------------------------------
// stack_machine_data_stack_unit
// Data stack of a stack machine: one primitive per instruction item.
// ----------------------------------------------------------------------------
// in_if carries an instruction item (opcode, literal); out_if returns one
// result item per instruction: status, top of stack, entry count, and the
// branch target or emitted value where the primitive produces one.
// One instruction is in flight at a time; in_if.ready is high only while
// the unit waits for work. Between accept and result valid, most primitives
// step through read, execute and write; swap adds a second write; pick,
// poke and branch_if add a second read; div and mod with a nonzero
// divisor also wait for the divider. These steps come from the single-port
// stack RAM (read, then write back) and the one-bit-per-cycle divider.
// After the result the unit goes back to idle, where the next item is accepted.
// The result holds on out_if until out_if.ready; no new item is taken
// while it waits. Synchronous reset empties the stack (count to zero);
// the RAM contents are not cleared and need not be.
// ----------------------------------------------------------------------------
module stack_machine_data_stack_unit #(
  parameter int STACK_DEPTH = sdsu_pkg::STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sdsu_in_if.sink    in_if,
  sdsu_out_if.source out_if
);
  import sdsu_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sdsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sdsu_dp #(
    .DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (in_if.opcode),
    .in_literal      (in_if.literal),
    .out_status      (out_if.status),
    .out_top_value   (out_if.top_value),
    .out_stack_count (out_if.stack_count),
    .out_jump_valid  (out_if.jump_valid),
    .out_jump_target (out_if.jump_target),
    .out_emit_valid  (out_if.emit_valid),
    .out_emit_value  (out_if.emit_value)
  );
endmodule

[design/sdsu_checker.sv]
// ----------------------------------------------------------------------------
// sdsu_checker
// Port-level checks of the data stack unit, bound to the top level.
// ----------------------------------------------------------------------------
module sdsu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_top_value,
  input logic [6:0]  out_stack_count,
  input logic        out_jump_valid,
  input logic [31:0] out_jump_target
);
  import sdsu_pkg::*;

  // a pending result blocks new instructions
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_top_value))
    else $error("result dropped or changed while stalled");

  a_under_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNDER |-> out_stack_count == 7'd0)
    else $error("underflow left entries on the stack");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stack_count == 7'd0 && out_jump_valid == 1'b0
      |-> out_top_value == 32'd0 && out_jump_target == 32'd0)
    else $error("empty stack shows a nonzero top or target");
endmodule

bind stack_machine_data_stack_unit sdsu_checker u_sdsu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_status      (out_if.status),
  .out_top_value   (out_if.top_value),
  .out_stack_count (out_if.stack_count),
  .out_jump_valid  (out_if.jump_valid),
  .out_jump_target (out_if.jump_target)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the data stack unit. A queue of instruction items
// feeds a driver; each accepted item is run through a local stack predictor,
// and every result item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import sdsu_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;

  typedef struct {
    logic              marker;    // hold off until all results are back
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] lit;
    int                send_idle;
    int                recv_stall;
  } instr_t;

  typedef struct {
    logic [ST_W-1:0]      status;
    logic [DATA_W-1:0]    top;
    logic [CNT_OUT_W-1:0] cnt;
    logic                 jv;
    logic [DATA_W-1:0]    jt;
    logic                 ev;
    logic [DATA_W-1:0]    evv;
  } outcome_t;

  logic clk;
  logic rst_n;

  sdsu_in_if  in_if ();
  sdsu_out_if out_if ();

  stack_machine_data_stack_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  instr_t   pending_instrs[$];
  outcome_t expected_outcomes[$];
  logic [DATA_W-1:0] model_stack[DEPTH];
  int unsigned model_fill;
  int err_cnt;
  int acc_cnt;
  int sent_cnt;
  int send_idle;
  int recv_stall;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  function automatic outcome_t exec_primitive(input logic [OP_W-1:0] op,
                                              input logic [DATA_W-1:0] lit);
    outcome_t r;
    int unsigned needs;
    logic pushes;
    logic [DATA_W-1:0] a, b, v, idx;
    r = '{default: '0};
    r.status = ST_OK;
    needs = 0;
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE,
      OP_LE, OP_AND, OP_OR, OP_SWAP, OP_POKE, OP_BRANCH_IF: needs = 2;
      OP_NOT, OP_DUP, OP_DROP, OP_PICK, OP_BRANCH, OP_OUT: needs = 1;
      default: needs = 0;
    endcase
    pushes = (op == OP_LIT) || (op == OP_DUP) || (op == OP_DEPTH);
    if (model_fill < needs) begin
      model_fill = 0;
      r.status = ST_UNDER;
    end else if (pushes && model_fill >= DEPTH) begin
      r.status = ST_OVER;
    end else if (needs == 2 && op <= OP_OR) begin
      b = model_stack[model_fill-1];
      a = model_stack[model_fill-2];
      model_fill -= 2;
      case (op)
        OP_ADD: v = a + b;
        OP_SUB: v = a - b;
        OP_MUL: v = a * b;
        OP_DIV, OP_MOD: begin
          if (b == 0) begin
            v = 0;
            r.status = ST_DIVZ;
          end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
            v = (op == OP_DIV) ? a : 32'd0;
          end else begin
            v = (op == OP_DIV) ? $signed(a) / $signed(b) : $signed(a) % $signed(b);
          end
        end
        OP_EQ:  v = (a == b) ? 32'hFFFF_FFFF : 32'd0;
        OP_NE:  v = (a != b) ? 32'hFFFF_FFFF : 32'd0;
        OP_GT:  v = ($signed(a) >  $signed(b)) ? 32'd1 : 32'd0;
        OP_LT:  v = ($signed(a) <  $signed(b)) ? 32'd1 : 32'd0;
        OP_GE:  v = ($signed(a) >= $signed(b)) ? 32'd1 : 32'd0;
        OP_LE:  v = ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0;
        OP_AND: v = a & b;
        default: v = a | b;
      endcase
      model_stack[model_fill] = v;
      model_fill++;
    end else begin
      case (op)
        OP_LIT: begin
          model_stack[model_fill] = lit;
          model_fill++;
        end
        OP_NOT: model_stack[model_fill-1] = (model_stack[model_fill-1] == 0) ? 32'd1 : 32'd0;
        OP_DUP: begin
          model_stack[model_fill] = model_stack[model_fill-1];
          model_fill++;
        end
        OP_DROP: model_fill--;
        OP_SWAP: begin
          v = model_stack[model_fill-1];
          model_stack[model_fill-1] = model_stack[model_fill-2];
          model_stack[model_fill-2] = v;
        end
        OP_DEPTH: begin
          model_stack[model_fill] = model_fill - 1;
          model_fill++;
        end
        OP_PICK: begin
          model_fill--;
          idx = model_stack[model_fill];
          // unsigned compare: negative indexes are out of range too
          if (idx < model_fill) begin
            model_stack[model_fill] = model_stack[idx];
            model_fill++;
          end else begin
            r.status = ST_INDEX;
          end
        end
        OP_POKE: begin
          idx = model_stack[model_fill-1];
          v = model_stack[model_fill-2];
          model_fill -= 2;
          if (idx < model_fill) model_stack[idx] = v;
          else r.status = ST_INDEX;
        end
        OP_BRANCH: begin
          model_fill--;
          r.jt = model_stack[model_fill];
          r.jv = 1'b1;
        end
        OP_BRANCH_IF: begin
          a = model_stack[model_fill-1];
          b = model_stack[model_fill-2];
          model_fill -= 2;
          if (b != 0) begin
            r.jv = 1'b1;
            r.jt = a;
          end
        end
        OP_OUT: begin
          model_fill--;
          r.evv = model_stack[model_fill];
          r.ev = 1'b1;
        end
        default: ;
      endcase
    end
    r.top = model_fill ? model_stack[model_fill-1] : 32'd0;
    r.cnt = model_fill[CNT_OUT_W-1:0];
    return r;
  endfunction

  // result check, then prediction of the item accepted at this edge
  always @(posedge clk) begin
    outcome_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_outcomes.size() == 0) begin
        $display("result item with nothing expected at %0t", $time);
        err_cnt++;
      end else begin
        w = expected_outcomes.pop_front();
        if (out_if.status !== w.status)
          report("status", 32'(out_if.status), 32'(w.status));
        if (out_if.top_value !== w.top) report("top_value", out_if.top_value, w.top);
        if (out_if.stack_count !== w.cnt)
          report("stack_count", 32'(out_if.stack_count), 32'(w.cnt));
        if (out_if.jump_valid !== w.jv)
          report("jump_valid", 32'(out_if.jump_valid), 32'(w.jv));
        if (out_if.jump_target !== w.jt) report("jump_target", out_if.jump_target, w.jt);
        if (out_if.emit_valid !== w.ev)
          report("emit_valid", 32'(out_if.emit_valid), 32'(w.ev));
        if (out_if.emit_value !== w.evv) report("emit_value", out_if.emit_value, w.evv);
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      expected_outcomes.insert(expected_outcomes.size(),
                               exec_primitive(in_if.opcode, in_if.literal));
      acc_cnt++;
    end
  end

  // driver: a raised item stays up until the accept count catches up
  always @(negedge clk) begin
    instr_t it;
    if (rst_n) begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall);
      if (!(in_if.valid && acc_cnt != sent_cnt)) begin
        while (pending_instrs.size() != 0 && pending_instrs[0].marker &&
               expected_outcomes.size() == 0)
          void'(pending_instrs.pop_front());
        if (pending_instrs.size() == 0 || pending_instrs[0].marker ||
            $urandom_range(0, 99) < send_idle) begin
          in_if.valid <= 1'b0;
        end else begin
          it = pending_instrs.pop_front();
          send_idle  = it.send_idle;
          recv_stall = it.recv_stall;
          in_if.opcode  <= it.op;
          in_if.literal <= it.lit;
          in_if.valid   <= 1'b1;
          sent_cnt++;
        end
      end
    end
  end

  int cur_idle, cur_stall;

  function automatic logic [31:0] rand_literal();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 70);
      2: return -$urandom_range(1, 3);
      3: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'd0;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $urandom_range(0, 9);
    endcase
  endfunction

  task automatic queue_instr(input logic [OP_W-1:0] op, input logic [31:0] lit);
    pending_instrs.insert(pending_instrs.size(), '{1'b0, op, lit, cur_idle, cur_stall});
  endtask

  task automatic queue_hold();
    pending_instrs.insert(pending_instrs.size(), '{1'b1, OP_LIT, 32'd0, cur_idle, cur_stall});
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int sel;
    idle_tab  = '{0, 48, 0, 37};
    stall_tab = '{0, 0, 48, 37};
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = '0;
    in_if.literal = '0;
    out_if.ready = 1'b0;
    err_cnt = 0;
    acc_cnt = 0;
    sent_cnt = 0;
    send_idle = 0;
    recv_stall = 0;
    model_fill = 0;
    cur_idle = 0;
    cur_stall = 0;

    // directed part: underflow, wrap cases, divide by zero, indexes, branches
    queue_instr(OP_DROP, 32'd0);
    queue_instr(OP_DEPTH, 32'h5A5A_5A5A);
    queue_instr(OP_LIT, 32'h8000_0000);
    queue_instr(OP_LIT, 32'hFFFF_FFFF);
    queue_instr(OP_DIV, 32'd0);
    queue_instr(OP_LIT, 32'hFFFF_FFFF);
    queue_instr(OP_MOD, 32'd0);
    queue_instr(OP_LIT, 32'd0);
    queue_instr(OP_DIV, 32'd0);
    queue_instr(OP_LIT, 32'h7FFF_FFFF);
    queue_instr(OP_LIT, 32'd1);
    queue_instr(OP_ADD, 32'd0);
    queue_instr(OP_NOT, 32'd0);
    queue_instr(OP_LIT, 32'd100);
    queue_instr(OP_PICK, 32'd0);
    queue_instr(OP_LIT, 32'd0);
    queue_instr(OP_PICK, 32'd0);
    queue_instr(OP_LIT, 32'hFFFF_FFFF);
    queue_instr(OP_POKE, 32'd0);
    queue_instr(OP_LIT, 32'd0);
    queue_instr(OP_LIT, 32'd9);
    queue_instr(OP_BRANCH_IF, 32'd0);
    queue_instr(OP_LIT, 32'd4);
    queue_instr(OP_BRANCH, 32'd0);
    queue_instr(OP_OUT, 32'd0);
    queue_instr(5'd31, 32'hFFFF_FFFF);

    for (int ph = 0; ph < 4; ph++) begin
      cur_idle  = idle_tab[ph];
      cur_stall = stall_tab[ph];
      queue_hold();
      if (ph == 1 || ph == 3) begin
        // fill the stack past its top to hit overflow
        for (int k = 0; k < DEPTH + 2; k++) queue_instr(OP_LIT, $urandom);
        queue_instr(OP_DUP, 32'd0);
        queue_instr(OP_DEPTH, 32'd0);
      end
      for (int i = 0; i < 200; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
          queue_instr(OP_LIT, rand_literal());
        end else if (sel < 45) begin
          queue_instr(OP_LIT, $urandom_range(0, 12));
          queue_instr(($urandom_range(0, 1)) ? OP_PICK : OP_POKE, $urandom);
        end else if (sel < 52) begin
          queue_instr(OP_LIT, rand_literal());
          queue_instr(($urandom_range(0, 1)) ? OP_DIV : OP_MOD, $urandom);
        end else begin
          queue_instr(OP_W'($urandom_range(0, 31)), $urandom);
        end
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_instrs.size() == 0 && !in_if.valid && expected_outcomes.size() == 0);
    repeat (60) @(posedge clk);
    if (err_cnt == 0 && expected_outcomes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
